@@ hdl/sspi_pkg.sv @@
// ----------------------------------------------------------------------------
// sspi_pkg
// Shared types and constants for the stable sorted priority store: the input
// and result item structs, the operation and status codes, and the command
// group that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package sspi_pkg;

    // Field widths fixed by the item formats.
    localparam int PRI_W    = 8;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;

    // Default number of entries the store holds.
    localparam int DEFAULT_CAPACITY = 16;

    // Operation codes carried in the op field.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ENTRY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // One input item.
    typedef struct packed {
        logic             op;
        logic [PRI_W-1:0] new_priority;
        logic [TAG_W-1:0] new_tag;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PRI_W-1:0]    out_priority;
        logic [TAG_W-1:0]    out_tag;
        logic                last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;   // place the new entry into the sorted chain
        logic rotate;   // move every cell down by one, head wraps to the top
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [PRI_W-1:0] head_priority;
        logic [TAG_W-1:0] head_tag;
    } t_dp_stat;

endpackage

@@ hdl/sspi_dpath.sv @@
// ----------------------------------------------------------------------------
// sspi_dpath
// Row of storage cells that keeps the entries in ascending priority order.
// Every cell compares itself with the new priority at once, so an insert
// completes in parallel. A rotate moves the whole ring down by one cell,
// which presents the entries at the head one after another during a dump.
// ----------------------------------------------------------------------------
module sspi_dpath #(
    parameter int CAPACITY = sspi_pkg::DEFAULT_CAPACITY,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                i_clk,
    input  sspi_pkg::t_dp_cmd   i_cmd,
    input  logic [CW-1:0]       i_count,
    input  sspi_pkg::t_in_item  i_item,
    output sspi_pkg::t_dp_stat  o_stat
);

    logic [sspi_pkg::PRI_W-1:0] r_pri [CAPACITY];
    logic [sspi_pkg::TAG_W-1:0] r_tag [CAPACITY];

    // A cell moves up when it is unused or holds a strictly greater priority.
    // The list is sorted, so these flags form one run up to the top cell.
    logic [CAPACITY-1:0] take;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_take
        localparam logic [CW-1:0] IDX = CW'(gi);
        assign take[gi] = (IDX >= i_count) || (r_pri[gi] > i_item.new_priority);
    end

    // Cell update: load the new entry, take the neighbor below, or rotate.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam int UP = (gi + 1) % CAPACITY;
        logic first_take;

        if (gi == 0) begin : g_first
            assign first_take = take[gi];
        end else begin : g_rest
            assign first_take = take[gi] && !take[gi-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.rotate) begin
                r_pri[gi] <= r_pri[UP];
                r_tag[gi] <= r_tag[UP];
            end else if (i_cmd.insert && first_take) begin
                r_pri[gi] <= i_item.new_priority;
                r_tag[gi] <= i_item.new_tag;
            end else if (i_cmd.insert && take[gi]) begin
                if (gi > 0) begin
                    r_pri[gi] <= r_pri[(gi + CAPACITY - 1) % CAPACITY];
                    r_tag[gi] <= r_tag[(gi + CAPACITY - 1) % CAPACITY];
                end
            end
        end
    end

    // The head cell feeds the dump results.
    assign o_stat.head_priority = r_pri[0];
    assign o_stat.head_tag      = r_tag[0];

endmodule

@@ hdl/sspi_ctrl.sv @@
// ----------------------------------------------------------------------------
// sspi_ctrl
// Controller for the sorted store: accepts items, keeps the entry count,
// steps a dump through one full turn of the cell ring, and owns the result
// register that drives the output channel.
// ----------------------------------------------------------------------------
module sspi_ctrl #(
    parameter int CAPACITY = sspi_pkg::DEFAULT_CAPACITY,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int KW       = $clog2(CAPACITY)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sspi_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sspi_pkg::t_out_item o_out_item,
    output sspi_pkg::t_dp_cmd   o_cmd,
    output logic [CW-1:0]       o_count,
    input  sspi_pkg::t_dp_stat  i_stat
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
    localparam logic [KW-1:0] LAST_STEP  = KW'(CAPACITY - 1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [KW-1:0]       r_step, n_step;
    logic                r_out_valid, n_out_valid;
    sspi_pkg::t_out_item r_out_item, n_out_item;

    logic slot_free;
    logic accept;
    logic full;
    logic in_window;
    logic step_last;
    logic do_insert;
    logic do_rotate;

    // Handshake and status terms.
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && slot_free;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == FULL_COUNT);
    assign in_window  = (CW'(r_step) < r_count);
    assign step_last  = ((CW'(r_step) + CW'(1)) == r_count);

    // Datapath commands. During a dump the ring only waits on a stalled
    // result while it still has entries to show.
    assign do_insert = accept && (i_in_item.op == sspi_pkg::OP_INSERT) && !full;
    assign do_rotate = (r_state == S_DUMP) && (!in_window || slot_free);

    assign o_cmd.insert = do_insert;
    assign o_cmd.rotate = do_rotate;
    assign o_count      = r_count;

    // Next-state logic for the sequencer and the result register.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_item.out_priority = '0;
                    n_out_item.out_tag      = '0;
                    n_out_item.last         = 1'b1;
                    if (i_in_item.op == sspi_pkg::OP_INSERT) begin
                        n_out_valid = 1'b1;
                        if (full) begin
                            n_out_item.status = sspi_pkg::ST_DROPPED;
                        end else begin
                            n_out_item.status = sspi_pkg::ST_INSERTED;
                            n_count           = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_out_valid       = 1'b1;
                        n_out_item.status = sspi_pkg::ST_EMPTY;
                    end else begin
                        n_state = S_DUMP;
                        n_step  = '0;
                    end
                end
            end
            S_DUMP: begin
                if (do_rotate) begin
                    if (in_window) begin
                        n_out_valid             = 1'b1;
                        n_out_item.status       = sspi_pkg::ST_ENTRY;
                        n_out_item.out_priority = i_stat.head_priority;
                        n_out_item.out_tag      = i_stat.head_tag;
                        n_out_item.last         = step_last;
                    end
                    if (r_step == LAST_STEP) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step = r_step + KW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ hdl/stable_sorted_priority_insert.sv @@
// ----------------------------------------------------------------------------
// stable_sorted_priority_insert
// Bounded store of priority and tag entries kept in ascending priority order,
// with equal priorities in arrival order. Supports insert and in-order dump.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid, o_in_ready, i_in_item): op selects an insert of
//   new_priority/new_tag or a dump of the whole store.
//   Output channel (o_out_valid, i_out_ready, o_out_item): each insert gives
//   one item with status inserted or dropped (store full). A dump gives one
//   item per stored entry, lowest priority first, last set on the final one;
//   a dump of an empty store gives a single empty item.
//   An insert result appears in the cycle after the item is taken; the
//   cell row compares and shifts in that same cycle, so inserts can be taken
//   every cycle while the receiver keeps up.
//   A dump turns the ring of CAPACITY cells once: from the dump state the head
//   entry goes into the result register, then one entry per cycle while the
//   receiver keeps up, and the input is taken again once the turn is done.
//   When the receiver stalls, the result register holds its item and no new
//   item is taken; a dump pauses its ring while entries remain to be shown.
//   Reset (synchronous, active low) empties the store and the result register.
// ----------------------------------------------------------------------------
module stable_sorted_priority_insert #(
    parameter int CAPACITY = sspi_pkg::DEFAULT_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sspi_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sspi_pkg::t_out_item o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = $clog2(CAPACITY);

    sspi_pkg::t_dp_cmd  cmd;
    sspi_pkg::t_dp_stat stat;
    logic [CW-1:0]      count;

    // Sequencer and result register.
    sspi_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW),
        .KW       (KW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_cmd       (cmd),
        .o_count     (count),
        .i_stat      (stat)
    );

    // Sorted cell row.
    sspi_dpath #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_count (count),
        .i_item  (i_in_item),
        .o_stat  (stat)
    );

    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A taken insert always has its result ready on the next cycle.
    a_insert_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_item.op == sspi_pkg::OP_INSERT))
        |=> o_out_valid)
        else $error("insert did not produce a result");

    // Only dump entries carry a priority and a tag.
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != sspi_pkg::ST_ENTRY))
        |-> (o_out_item.out_priority == '0 && o_out_item.out_tag == '0
             && o_out_item.last))
        else $error("non-entry result carries payload or misses last");

    // A datapath insert never happens while the store is full or during a dump rotate.
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.insert |-> (count != CW'(CAPACITY)) && !cmd.rotate)
        else $error("insert issued into a full store or during a dump");

endmodule

@@ tb/stable_sorted_priority_insert_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_sorted_priority_insert_tb
// Self-checking testbench for the sorted priority store. A queue of pending
// items feeds a clocked driver, and a clocked monitor drains the result
// channel. Every accepted item runs through a local model of the sorted store,
// and each result is checked field by field against the oldest expectation.
// The run covers directed corner cases, then random items under several
// idle and stall mixes, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module stable_sorted_priority_insert_tb;

    localparam int STORE_DEPTH    = sspi_pkg::DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_OFF_LEN   = 80;
    localparam int ITEMS_PER_STEP = 15;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    sspi_pkg::t_in_item  i_in_item   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    sspi_pkg::t_out_item o_out_item;

    // Stimulus control, written by the sequencer on the falling edge.
    sspi_pkg::t_in_item  pending_items[$];
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    logic                hold_off_armed = 1'b0;

    // Receiver hold-off counter, owned by its own process.
    int                  hold_off_count = 0;

    // Expected results and the model of the sorted store.
    sspi_pkg::t_out_item        expected_results[$];
    logic [sspi_pkg::PRI_W-1:0] store_pri [STORE_DEPTH];
    logic [sspi_pkg::TAG_W-1:0] store_tag [STORE_DEPTH];
    int                         store_count = 0;

    int                  error_count = 0;
    int                  cycle_count = 0;
    logic                send_holding;

    stable_sorted_priority_insert #(
        .CAPACITY(STORE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Apply one accepted item to the sorted store and queue its results.
    function automatic void apply_to_store(sspi_pkg::t_in_item item);
        sspi_pkg::t_out_item res;
        int                  pos;
        logic                found;
        res      = '0;
        res.last = 1'b1;
        if (item.op == sspi_pkg::OP_INSERT) begin
            if (store_count >= STORE_DEPTH) begin
                res.status = sspi_pkg::ST_DROPPED;
            end else begin
                // The new entry goes ahead of the first strictly greater one.
                pos   = store_count;
                found = 1'b0;
                for (int i = 0; i < store_count; i++) begin
                    if (!found && store_pri[i] > item.new_priority) begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                for (int i = store_count; i > pos; i--) begin
                    store_pri[i] = store_pri[i-1];
                    store_tag[i] = store_tag[i-1];
                end
                store_pri[pos] = item.new_priority;
                store_tag[pos] = item.new_tag;
                store_count++;
                res.status = sspi_pkg::ST_INSERTED;
            end
            expected_results.push_back(res);
        end else if (store_count == 0) begin
            res.status = sspi_pkg::ST_EMPTY;
            expected_results.push_back(res);
        end else begin
            for (int i = 0; i < store_count; i++) begin
                res.status       = sspi_pkg::ST_ENTRY;
                res.out_priority = store_pri[i];
                res.out_tag      = store_tag[i];
                res.last         = (i == store_count - 1);
                expected_results.push_back(res);
            end
        end
    endfunction

    // Compare one result item with the oldest expectation.
    function automatic void check_result(sspi_pkg::t_out_item got);
        sspi_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d pri=%0h tag=%0h last=%0b",
                     $time, got.status, got.out_priority, got.out_tag, got.last);
            error_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, got %0d",
                         $time, want.status, got.status);
                error_count++;
            end
            if (got.out_priority !== want.out_priority) begin
                $display("%0t: out_priority expected %0h, got %0h",
                         $time, want.out_priority, got.out_priority);
                error_count++;
            end
            if (got.out_tag !== want.out_tag) begin
                $display("%0t: out_tag expected %0h, got %0h",
                         $time, want.out_tag, got.out_tag);
                error_count++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
                error_count++;
            end
        end
    endfunction

    // Random item, with priorities biased toward a few values to force ties.
    function automatic sspi_pkg::t_in_item random_item();
        sspi_pkg::t_in_item item;
        item.op = ($urandom_range(99) < 25) ? sspi_pkg::OP_DUMP : sspi_pkg::OP_INSERT;
        case ($urandom_range(3))
            0: item.new_priority = 8'h00;
            1: item.new_priority = 8'h80 + 8'($urandom_range(1));
            2: item.new_priority = 8'hFF;
            default: item.new_priority = 8'($urandom_range(255));
        endcase
        item.new_tag = 16'($urandom_range(16'hFFFF));
        return item;
    endfunction

    task automatic queue_item(logic op, logic [sspi_pkg::PRI_W-1:0] pri,
                              logic [sspi_pkg::TAG_W-1:0] tag);
        sspi_pkg::t_in_item item;
        item.op           = op;
        item.new_priority = pri;
        item.new_tag      = tag;
        pending_items.push_back(item);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++) begin
            pending_items.push_back(random_item());
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Driver: offers the pending items and holds each one until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            send_holding = i_in_valid && !o_in_ready;
            if (i_in_valid && o_in_ready) begin
                apply_to_store(i_in_item);
            end
            if (!send_holding) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_item  <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Hold-off counter: counts the cycles of the long receiver stall.
    always @(posedge i_clk) begin
        if (hold_off_armed && hold_off_count < HOLD_OFF_LEN) begin
            hold_off_count <= hold_off_count + 1;
        end
    end

    // Monitor: checks each result and drives the receiver's ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_result(o_out_item);
            end
            if (hold_off_armed && hold_off_count < HOLD_OFF_LEN) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sequencer: reset, then directed and random items under each idle mix.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty dump, extremes, ties in arrival order, then a dump.
        queue_item(sspi_pkg::OP_DUMP,   8'h00, 16'h0000);
        queue_item(sspi_pkg::OP_INSERT, 8'h80, 16'h1111);
        queue_item(sspi_pkg::OP_INSERT, 8'h80, 16'h2222);
        queue_item(sspi_pkg::OP_INSERT, 8'h00, 16'h0000);
        queue_item(sspi_pkg::OP_INSERT, 8'hFF, 16'hFFFF);
        queue_item(sspi_pkg::OP_INSERT, 8'h80, 16'h3333);
        queue_item(sspi_pkg::OP_INSERT, 8'h00, 16'hAAAA);
        queue_item(sspi_pkg::OP_INSERT, 8'hFF, 16'h5555);
        queue_item(sspi_pkg::OP_DUMP,   8'hFF, 16'hFFFF);
        // Fill the store to the brim, then overfill it and dump it whole.
        for (int i = 0; i < STORE_DEPTH - 7; i++) begin
            queue_item(sspi_pkg::OP_INSERT, 8'h7F + 8'(i[1:0]), 16'hC000 + 16'(i));
        end
        queue_item(sspi_pkg::OP_INSERT, 8'h00, 16'hDEAD);
        queue_item(sspi_pkg::OP_DUMP,   8'h00, 16'h0000);
        queue_item(sspi_pkg::OP_INSERT, 8'hFF, 16'hBEEF);

        // Random items with no idling on either side.
        queue_random(ITEMS_PER_STEP);
        wait_drained();

        // Sender idle most of the time.
        send_idle_pct  = 72;
        recv_stall_pct = 0;
        queue_random(ITEMS_PER_STEP);
        wait_drained();

        // Receiver stalling most of the time.
        send_idle_pct  = 0;
        recv_stall_pct = 72;
        queue_random(ITEMS_PER_STEP);
        wait_drained();

        // Light idling on both sides.
        send_idle_pct  = 16;
        recv_stall_pct = 16;
        queue_random(ITEMS_PER_STEP);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering items.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_armed = 1'b1;
        queue_random(ITEMS_PER_STEP);
        wait_drained();
        hold_off_armed = 1'b0;

        // Let a dump that might still be turning its ring settle.
        repeat (2 * STORE_DEPTH + 4) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/sspi_pkg.sv
hdl/sspi_dpath.sv
hdl/sspi_ctrl.sv
hdl/stable_sorted_priority_insert.sv
tb/stable_sorted_priority_insert_tb.sv
